### design/next_fit_block_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Check an expression at every clock edge outside reset.
`define NFBA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define NFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### design/nfba_pkg.sv
// Types and constants of the next-fit block allocator.
`timescale 1ns / 1ps

package nfba_pkg;

  localparam int CMD_W     = 2;
  localparam int REQ_W     = 13;
  localparam int OFF_W     = 12;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_HEAD = 2'd1,
    MARK_TAIL = 2'd2
  } mark_e;

  typedef struct packed {
    logic [REQ_W-1:0] quotient;
    logic             rem_nz;
  } div_res_t;

endpackage

### design/nfba_if.sv
// Request and response channel interfaces of the allocator.
`timescale 1ns / 1ps

interface nfba_req_if
  import nfba_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] free_offset;

  modport source (output valid, output cmd, output request_bytes, output free_offset,
                  input ready);
  modport sink   (input valid, input cmd, input request_bytes, input free_offset,
                  output ready);
endinterface

interface nfba_rsp_if
  import nfba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  alloc_offset;

  modport source (output valid, output status, output alloc_offset, input ready);
  modport sink   (input valid, input status, input alloc_offset, output ready);
endinterface

### design/nfba_div.sv
// Division by the block size through a reciprocal multiply; done_o follows stage_q.
`timescale 1ns / 1ps

module nfba_div
  import nfba_pkg::*;
#(
  parameter int BLOCK_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REQ_W-1:0] dividend_i,
  output logic             done_o,
  output div_res_t         res_o
);

  // x * RECIP >> SHIFT equals x / BLOCK_BYTES for every REQ_W-bit x.
  localparam int SHIFT  = REQ_W + $clog2(BLOCK_BYTES);
  localparam int RECIP  = ((1 << SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int MW     = REQ_W + 1;
  localparam int PROD_W = REQ_W + MW;
  localparam int BW     = 2 * REQ_W;
  localparam logic [MW-1:0]    RECIP_M = MW'(RECIP);
  localparam logic [REQ_W-1:0] DIVISOR = REQ_W'(BLOCK_BYTES);

  logic              stage_q;
  logic              done_q;
  logic [REQ_W-1:0]  num_q;
  logic [REQ_W-1:0]  quo_q, quo_d;
  logic              rem_nz_q, rem_nz_d;
  logic [PROD_W-1:0] prod;
  logic [BW-1:0]     back;

  assign prod     = PROD_W'(dividend_i) * PROD_W'(RECIP_M);
  assign quo_d    = REQ_W'(prod >> SHIFT);
  // Multiply back from the registered quotient to see whether anything is left over.
  assign back     = BW'(quo_q) * BW'(DIVISOR);
  assign rem_nz_d = (back != BW'(num_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      quo_q <= quo_d;
    end
    if (stage_q) begin
      rem_nz_q <= rem_nz_d;
    end
  end

  assign done_o         = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.rem_nz   = rem_nz_q;

endmodule

### design/next_fit_block_allocator.sv
// Top level of the next-fit contiguous block allocator.
//
// Commands arrive on req_i (valid/ready); each one gives exactly one transfer on
// rsp_o with a status and, for a successful allocate, the byte offset of the run.
// One command is worked on at a time; req_i.ready is high only while idle, and a
// response still waiting on rsp_o does not block acceptance of the next command.
// What each command does before rsp_o.valid rises:
//   allocate: scans the map from the next-fit pointer towards the map end over
//             the single map read port and marks the run when one fits, else
//             answers no fit; an oversize request is answered without a scan.
//   free:     releases the addressed block and each trailing tail after it;
//             an offset beyond the pool is answered without touching the map.
//   clear:    one map entry written per cycle; an unused code gets a done status.
// req_i.ready returns in the cycle rsp_o.valid rises. After reset the block runs
// a clearing pass over every map entry with req_i.ready low. When rsp_o stalls, a
// finished result holds in the output register and the next one waits, with
// req_i.ready low, until that register frees.
`timescale 1ns / 1ps

module next_fit_block_allocator
  import nfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  nfba_req_if.sink        req_i,
  nfba_rsp_if.source      rsp_o
);

`include "next_fit_block_allocator_assert.svh"

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int PW = $clog2(NUM_BLOCKS + 1);
  localparam int NW = REQ_W + 1;
  localparam logic [PW-1:0] NUM_P = PW'(NUM_BLOCKS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } state_e;

  state_e            state_q;
  cmd_e              cmd_q;
  logic [PW-1:0]     ptr_q;
  logic [PW-1:0]     idx_q;
  logic [IW-1:0]     chk_q;
  logic              pend_q;
  logic [PW-1:0]     run_q;
  logic [PW-1:0]     need_q;
  logic [IW-1:0]     head_q;
  logic              clr_rsp_q;
  status_e           res_status_q;
  logic              res_alloc_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [OFF_W-1:0]  out_offset_q;

  // Block map memory
  mark_e             map_q [NUM_BLOCKS];
  mark_e             rd_data_q;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  mark_e             mem_wdata;
  logic [IW-1:0]     mem_raddr;

  // Divider
  logic              div_start;
  logic [REQ_W-1:0]  div_dividend;
  logic              div_done;
  div_res_t          div_res;

  logic              accept;
  logic              issue;
  logic [PW-1:0]     run_inc;
  logic [NW-1:0]     need_raw;
  logic [NW-1:0]     need_w;
  logic              too_big;
  logic              free_oob;
  logic              out_free;
  logic              need_ok;
  logic              rsp_fail;

  assign accept   = req_i.valid && req_i.ready;
  assign issue    = (idx_q < NUM_P);
  assign run_inc  = run_q + 1'b1;
  assign need_raw = {1'b0, div_res.quotient} + NW'(div_res.rem_nz);
  assign need_w   = (need_raw == '0) ? NW'(1) : need_raw;
  assign too_big  = (32'(need_w) > 32'(NUM_BLOCKS));
  assign free_oob = (32'(div_res.quotient) >= 32'(NUM_BLOCKS));
  assign out_free = !out_valid_q || rsp_o.ready;

  assign div_start    = accept && ((cmd_e'(req_i.cmd) == CMD_ALLOC) ||
                                   (cmd_e'(req_i.cmd) == CMD_FREE));
  assign div_dividend = (cmd_e'(req_i.cmd) == CMD_ALLOC) ? req_i.request_bytes
                                                          : REQ_W'(req_i.free_offset);

  nfba_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  assign mem_raddr = idx_q[IW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[IW-1:0];
    mem_wdata = MARK_FREE;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_DECIDE: begin
        // Release the addressed block itself.
        if (cmd_q == CMD_FREE && !free_oob) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(div_res.quotient);
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = (idx_q[IW-1:0] == head_q) ? MARK_HEAD : MARK_TAIL;
      end
      S_FREE: begin
        if (pend_q && rd_data_q == MARK_TAIL) begin
          mem_we    = 1'b1;
          mem_waddr = chk_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= map_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cmd_q        <= CMD_ALLOC;
      ptr_q        <= '0;
      idx_q        <= '0;
      chk_q        <= '0;
      pend_q       <= 1'b0;
      run_q        <= '0;
      need_q       <= '0;
      head_q       <= '0;
      clr_rsp_q    <= 1'b0;
      res_status_q <= STAT_DONE;
      res_alloc_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_DONE;
      out_offset_q <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          ptr_q <= '0;
          idx_q <= idx_q + 1'b1;
          if (idx_q == PW'(NUM_BLOCKS - 1)) begin
            res_status_q <= STAT_DONE;
            res_alloc_q  <= 1'b0;
            state_q      <= clr_rsp_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_alloc_q <= 1'b0;
            unique case (cmd_e'(req_i.cmd))
              CMD_ALLOC: begin
                cmd_q   <= CMD_ALLOC;
                state_q <= S_DIV;
              end
              CMD_FREE: begin
                cmd_q   <= CMD_FREE;
                state_q <= S_DIV;
              end
              CMD_CLEAR: begin
                idx_q     <= '0;
                clr_rsp_q <= 1'b1;
                state_q   <= S_CLEAR;
              end
              default: begin
                res_status_q <= STAT_DONE;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pend_q <= 1'b0;
          run_q  <= '0;
          if (cmd_q == CMD_ALLOC) begin
            if (too_big) begin
              res_status_q <= STAT_NOFIT;
              state_q      <= S_DONE;
            end else begin
              need_q  <= PW'(need_w);
              idx_q   <= ptr_q;
              state_q <= S_SCAN;
            end
          end else begin
            if (free_oob) begin
              res_status_q <= STAT_RANGE;
              state_q      <= S_DONE;
            end else begin
              ptr_q   <= PW'(div_res.quotient);
              idx_q   <= PW'(div_res.quotient) + 1'b1;
              state_q <= S_FREE;
            end
          end
        end
        S_SCAN: begin
          // Read one entry ahead while checking the one that just came back.
          pend_q <= issue;
          if (issue) begin
            idx_q <= idx_q + 1'b1;
            chk_q <= idx_q[IW-1:0];
          end
          if (pend_q) begin
            if (rd_data_q == MARK_FREE) begin
              run_q <= run_inc;
              if (run_inc == need_q) begin
                head_q       <= IW'(PW'(chk_q) - need_q + 1'b1);
                idx_q        <= PW'(chk_q) - need_q + 1'b1;
                ptr_q        <= PW'(chk_q) + 1'b1;
                res_status_q <= STAT_DONE;
                res_alloc_q  <= 1'b1;
                state_q      <= S_MARK;
              end
            end else begin
              run_q <= '0;
            end
          end else if (!issue) begin
            res_status_q <= STAT_NOFIT;
            state_q      <= S_DONE;
          end
        end
        S_MARK: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == ptr_q) begin
            state_q <= S_DONE;
          end
        end
        S_FREE: begin
          pend_q <= issue;
          if (issue) begin
            idx_q <= idx_q + 1'b1;
            chk_q <= idx_q[IW-1:0];
          end
          // Stop at the first entry that is not a tail, or at the end of the map.
          if ((pend_q && rd_data_q != MARK_TAIL) || (!pend_q && !issue)) begin
            res_status_q <= STAT_DONE;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_offset_q <= res_alloc_q ? OFF_W'(32'(head_q) * 32'(BLOCK_BYTES)) : '0;
            clr_rsp_q    <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.alloc_offset = out_offset_q;

  assign need_ok  = (need_q != '0) && (need_q <= NUM_P);
  assign rsp_fail = rsp_o.valid && (rsp_o.status != STAT_DONE);

  `NFBA_ASSERT_ALWAYS(a_ptr_range, ptr_q <= NUM_P, "next-fit pointer beyond map end")
  `NFBA_ASSERT_IMPL(a_scan_need, state_q == S_SCAN, need_ok, "scan with bad run length")
  `NFBA_ASSERT_IMPL(a_mark_bound, state_q == S_MARK, idx_q < ptr_q, "marking past end of run")
  `NFBA_ASSERT_IMPL(a_fail_offset, rsp_fail, rsp_o.alloc_offset == '0, "offset on failure")
  `NFBA_ASSERT_NEXT(a_busy_after_accept, accept, !req_i.ready, "ready while busy")

endmodule
